/* rtl/bprb_pkg.sv */
// ----------------------------------------------------------------------------
// bprb_pkg
// Shared types and constants for the byte pipe ring buffer unit.
// ----------------------------------------------------------------------------
package bprb_pkg;

	localparam int DEPTH       = 4096;
	localparam int PTR_W       = $clog2(DEPTH);
	localparam int FILL_W      = 12;
	localparam int LEN_W       = 16;
	localparam int LIMIT_W     = 12;
	localparam int HALF_DEPTH  = DEPTH / 2;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(512);
	localparam logic [1:0] OPEN_BOTH = 2'd2;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_POLL  = 2'd2,
		OP_CLOSE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_WOULD_BLOCK = 3'd1,
		ST_EOS         = 3'd2,
		ST_DENIED      = 3'd3,
		ST_BROKEN      = 3'd4,
		ST_RETRY       = 3'd5,
		ST_FULL        = 3'd6
	} status_t;

	localparam logic END_READ  = 1'b0;
	localparam logic END_WRITE = 1'b1;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

/* rtl/byte_pipe_ring_buffer_unit.sv */
// ----------------------------------------------------------------------------
// byte_pipe_ring_buffer_unit
// Byte pipe on a 4096-byte ring with read/write/poll/close accesses.
// Sequence: the accepting edge moves to execute, and done is registered at
// its end. No new word is taken while busy (memory read register, then execute).
// Reset: pointers zero, both ends open, atomic_limit 512; ring contents
// undefined, no clearing pass. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module byte_pipe_ring_buffer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    opcode,
	input  logic                          end_select,
	input  logic [7:0]                    write_data,
	input  logic                          request_first,
	input  logic [bprb_pkg::LEN_W-1:0]    request_length,
	input  logic [3:0]                    poll_mask,
	output logic                          done,
	output logic [2:0]                    status,
	output logic [7:0]                    read_data,
	output logic [3:0]                    poll_events,
	output logic [bprb_pkg::FILL_W-1:0]   fill_level,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bprb_pkg::LIMIT_W-1:0]  cfg_data
);
	import bprb_pkg::*;

	cmd_t cmd;

	assign cfg_ready = 1'b1;

	bprb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	bprb_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.opcode         (opcode),
		.end_select     (end_select),
		.write_data     (write_data),
		.request_first  (request_first),
		.request_length (request_length),
		.poll_mask      (poll_mask),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_data       (cfg_data),
		.status         (status),
		.read_data      (read_data),
		.poll_events    (poll_events),
		.fill_level     (fill_level)
	);

endmodule

/* rtl/bprb_ctrl.sv */
// ----------------------------------------------------------------------------
// bprb_ctrl
// Sequencer: takes a word, runs the execute state, strobes the result.
// ----------------------------------------------------------------------------
module bprb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output bprb_pkg::cmd_t cmd
);
	import bprb_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) state_q <= S_EXEC;
				end
				S_EXEC: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q == S_EXEC);
	assign done     = done_q;
	assign cmd.load = start && (state_q == S_IDLE);
	assign cmd.exec = (state_q == S_EXEC);

`ifndef NO_ASSERTIONS
	a_load_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec)
		else $error("accepted word did not enter execute");
	a_exec_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> (done && !busy))
		else $error("execute did not strobe a result");
	a_done_only_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.exec))
		else $error("result strobe without execute");
`endif

endmodule

/* rtl/bprb_dp.sv */
// ----------------------------------------------------------------------------
// bprb_dp
// Datapath: ring memory, pointers, end state, limit register, result regs.
// ----------------------------------------------------------------------------
module bprb_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bprb_pkg::cmd_t                cmd,
	input  logic [1:0]                    opcode,
	input  logic                          end_select,
	input  logic [7:0]                    write_data,
	input  logic                          request_first,
	input  logic [bprb_pkg::LEN_W-1:0]    request_length,
	input  logic [3:0]                    poll_mask,
	input  logic                          cfg_we,
	input  logic [bprb_pkg::LIMIT_W-1:0]  cfg_data,
	output logic [2:0]                    status,
	output logic [7:0]                    read_data,
	output logic [3:0]                    poll_events,
	output logic [bprb_pkg::FILL_W-1:0]   fill_level
);
	import bprb_pkg::*;

	logic [7:0]        ring_q [DEPTH];
	logic [7:0]        rd_s1;

	logic [PTR_W-1:0]  head_q, tail_q;
	logic [1:0]        open_q;
	logic              reject_q;
	logic [LIMIT_W-1:0] limit_q;

	op_t               op_q;
	logic              end_q;
	logic [7:0]        wdata_q;
	logic              first_q;
	logic [LEN_W-1:0]  len_q;
	logic [3:0]        mask_q;

	logic [2:0]        status_q;
	logic [7:0]        rdata_q;
	logic [3:0]        events_q;
	logic [FILL_W-1:0] fill_q;

	status_t           st_d;
	logic [7:0]        rdata_d;
	logic [3:0]        events_d;
	logic [PTR_W-1:0]  head_d, tail_d, fill_now, free_now, fill_after, tail_inc;
	logic [1:0]        open_d;
	logic              reject_d, rej_cur, atomic, we;

	always_ff @(posedge clk) begin
		if (we) ring_q[tail_q] <= wdata_q;
		if (cmd.load) rd_s1 <= ring_q[head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(opcode);
			end_q   <= end_select;
			wdata_q <= write_data;
			first_q <= request_first;
			len_q   <= request_length;
			mask_q  <= poll_mask;
		end
		if (cmd.exec) begin
			status_q <= st_d;
			rdata_q  <= rdata_d;
			events_q <= events_d;
			fill_q   <= FILL_W'(fill_after);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			open_q   <= OPEN_BOTH;
			reject_q <= 1'b0;
			limit_q  <= LIMIT_RESET;
		end else begin
			if (cmd.exec) begin
				head_q   <= head_d;
				tail_q   <= tail_d;
				open_q   <= open_d;
				reject_q <= reject_d;
			end
			if (cfg_we) limit_q <= cfg_data;
		end
	end

	assign fill_now   = tail_q - head_q;
	assign free_now   = PTR_W'(DEPTH - 1) - fill_now;
	assign tail_inc   = tail_q + PTR_W'(1);
	assign atomic     = len_q <= LEN_W'(limit_q);
	assign fill_after = tail_d - head_d;

	always_comb begin
		st_d     = ST_OK;
		rdata_d  = 8'd0;
		events_d = 4'd0;
		head_d   = head_q;
		tail_d   = tail_q;
		open_d   = open_q;
		reject_d = reject_q;
		rej_cur  = reject_q;
		we       = 1'b0;
		unique case (op_q)
			OP_READ: begin
				if (end_q != END_READ) begin
					st_d = ST_DENIED;
				end else if (head_q == tail_q) begin
					st_d = (open_q == OPEN_BOTH) ? ST_WOULD_BLOCK : ST_EOS;
				end else begin
					rdata_d = rd_s1;
					head_d  = head_q + PTR_W'(1);
				end
			end
			OP_WRITE: begin
				if (end_q != END_WRITE) begin
					st_d = ST_DENIED;
				end else begin
					if (first_q) rej_cur = 1'b0;
					reject_d = rej_cur;
					if (open_q != OPEN_BOTH) begin
						st_d = ST_BROKEN;
					end else if (first_q && atomic && (LEN_W'(free_now) < len_q)) begin
						reject_d = 1'b1;
						st_d     = ST_RETRY;
					end else if (rej_cur) begin
						st_d = atomic ? ST_RETRY : ST_FULL;
					end else if (tail_inc == head_q) begin
						reject_d = 1'b1;
						st_d     = ST_FULL;
					end else begin
						we     = cmd.exec;
						tail_d = tail_inc;
					end
				end
			end
			OP_POLL: begin
				if (end_q == END_READ) begin
					if (fill_now != '0) events_d = mask_q & 4'b0011;
				end else begin
					if (fill_now < PTR_W'(HALF_DEPTH)) events_d = mask_q & 4'b1100;
				end
			end
			OP_CLOSE: begin
				if (open_q != 2'd0) open_d = open_q - 2'd1;
			end
			default: st_d = ST_OK;
		endcase
	end

	assign status      = status_q;
	assign read_data   = rdata_q;
	assign poll_events = events_q;
	assign fill_level  = fill_q;

`ifndef NO_ASSERTIONS
	a_never_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (tail_inc != head_q))
		else $error("write into full ring");
	a_open_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= OPEN_BOTH)
		else $error("open end count out of range");
	a_ptr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cmd.exec) |-> ($stable(head_q) && $stable(tail_q)))
		else $error("pointer moved outside execute");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for byte_pipe_ring_buffer_unit. A local model of the
// pipe predicts every access word; results are checked field by field as
// they are strobed. Directed tests cover wrong-end access, empty reads,
// all-or-nothing shortfall, ring full and closing of both ends. Random
// request traffic runs under three atomic_limit settings and three sender
// idle rates.
// ----------------------------------------------------------------------------
module tb;
	import bprb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		status_t               status;
		logic [7:0]            rdata;
		logic [3:0]            events;
		logic [FILL_W-1:0]     fill;
	} pipe_result_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          opcode;
	logic                end_select;
	logic [7:0]          write_data;
	logic                request_first;
	logic [LEN_W-1:0]    request_length;
	logic [3:0]          poll_mask;
	logic                done;
	logic [2:0]          status;
	logic [7:0]          read_data;
	logic [3:0]          poll_events;
	logic [FILL_W-1:0]   fill_level;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [LIMIT_W-1:0]  cfg_data;

	// pipe model state
	logic [7:0]          ring_m [0:DEPTH-1];
	logic [PTR_W-1:0]    head_m = '0;
	logic [PTR_W-1:0]    tail_m = '0;
	logic [1:0]          open_m = OPEN_BOTH;
	logic                reject_m = 1'b0;
	logic [LIMIT_W-1:0]  limit_m = LIMIT_RESET;

	pipe_result_t        pending_results[$];
	int                  mismatch_count = 0;
	int                  results_seen = 0;
	int                  words_sent = 0;
	int                  sender_idle_pct = 0;
	int                  cycle_count = 0;

	byte_pipe_ring_buffer_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.end_select     (end_select),
		.write_data     (write_data),
		.request_first  (request_first),
		.request_length (request_length),
		.poll_mask      (poll_mask),
		.done           (done),
		.status         (status),
		.read_data      (read_data),
		.poll_events    (poll_events),
		.fill_level     (fill_level),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [FILL_W-1:0] ring_fill();
		logic [PTR_W-1:0] diff;
		diff = tail_m - head_m;
		return FILL_W'(diff);
	endfunction

	function automatic pipe_result_t apply_access(input op_t op, input logic sel,
			input logic [7:0] data, input logic first, input logic [LEN_W-1:0] len,
			input logic [3:0] mask);
		pipe_result_t r;
		logic         atomic;
		int           free_bytes;
		r.status = ST_OK;
		r.rdata = 8'h00;
		r.events = 4'h0;
		atomic = (int'(len) <= int'(limit_m));
		free_bytes = DEPTH - 1 - int'(ring_fill());
		case (op)
			OP_READ: begin
				if (sel != END_READ) begin
					r.status = ST_DENIED;
				end else if (head_m == tail_m) begin
					r.status = (open_m == OPEN_BOTH) ? ST_WOULD_BLOCK : ST_EOS;
				end else begin
					r.rdata = ring_m[head_m];
					head_m = head_m + 1'b1;
				end
			end
			OP_WRITE: begin
				if (sel != END_WRITE) begin
					r.status = ST_DENIED;
				end else begin
					if (first)
						reject_m = 1'b0;
					if (open_m != OPEN_BOTH) begin
						r.status = ST_BROKEN;
					end else if (first && atomic && free_bytes < int'(len)) begin
						reject_m = 1'b1;
						r.status = ST_RETRY;
					end else if (reject_m) begin
						r.status = atomic ? ST_RETRY : ST_FULL;
					end else if (PTR_W'(tail_m + 1'b1) == head_m) begin
						reject_m = 1'b1;
						r.status = ST_FULL;
					end else begin
						ring_m[tail_m] = data;
						tail_m = tail_m + 1'b1;
					end
				end
			end
			OP_POLL: begin
				if (sel == END_READ) begin
					if (ring_fill() != 0)
						r.events = mask & 4'b0011;
				end else if (int'(ring_fill()) < HALF_DEPTH) begin
					r.events = mask & 4'b1100;
				end
			end
			default: begin
				if (open_m != 2'd0)
					open_m = open_m - 1'b1;
			end
		endcase
		r.fill = ring_fill();
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch on result %0d, %s: got %0h expected %0h (cycle %0d)",
			results_seen, what, got, want, cycle_count);
		mismatch_count++;
	endtask

	// result checker and model update, one edge at a time
	always @(posedge clk) begin : monitor
		pipe_result_t want;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with none pending", 16'(status), 16'h0);
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status)
						report_mismatch("status", 16'(status), 16'(want.status));
					if (read_data !== want.rdata)
						report_mismatch("read_data", 16'(read_data), 16'(want.rdata));
					if (poll_events !== want.events)
						report_mismatch("poll_events", 16'(poll_events), 16'(want.events));
					if (fill_level !== want.fill)
						report_mismatch("fill_level", 16'(fill_level), 16'(want.fill));
				end
				results_seen++;
			end
			if (start === 1'b1 && busy === 1'b0)
				pending_results.push_back(apply_access(op_t'(opcode), end_select,
					write_data, request_first, request_length, poll_mask));
			if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
				limit_m = cfg_data;
		end
	end

	task automatic send_word(input op_t op, input logic sel, input logic [7:0] data,
			input logic first, input logic [LEN_W-1:0] len, input logic [3:0] mask);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		end_select <= sel;
		write_data <= data;
		request_first <= first;
		request_length <= len;
		poll_mask <= mask;
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic do_write(input logic [7:0] data, input logic first,
			input logic [LEN_W-1:0] len);
		send_word(OP_WRITE, END_WRITE, data, first, len, 4'($urandom));
	endtask

	task automatic do_read();
		send_word(OP_READ, END_READ, 8'($urandom), 1'($urandom), 16'($urandom),
			4'($urandom));
	endtask

	task automatic do_poll(input logic sel, input logic [3:0] mask);
		send_word(OP_POLL, sel, 8'($urandom), 1'($urandom), 16'($urandom), mask);
	endtask

	task automatic do_close(input logic sel);
		send_word(OP_CLOSE, sel, 8'($urandom), 1'($urandom), 16'($urandom),
			4'($urandom));
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_atomic_limit(input logic [LIMIT_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_access_rules();
		do_read();
		send_word(OP_READ, END_WRITE, 8'h00, 1'b0, 16'h0000, 4'h0);
		send_word(OP_WRITE, END_READ, 8'hFF, 1'b1, 16'hFFFF, 4'hF);
		do_poll(END_READ, 4'hF);
		do_poll(END_WRITE, 4'hF);
		do_write(8'h00, 1'b1, 16'd3);
		do_write(8'hFF, 1'b0, 16'd3);
		do_write(8'hA5, 1'b0, 16'd3);
		do_poll(END_READ, 4'b0101);
		do_poll(END_WRITE, 4'b1010);
		repeat (3) do_read();
		do_read();
		do_write(8'h5A, 1'b1, 16'd0);
		do_read();
	endtask

	// default limit 512: shortfall near the top, then ring full
	task automatic test_fill_to_full();
		do_write(8'($urandom), 1'b1, 16'hFFFF);
		while (ring_fill() < 3584)
			do_write(8'($urandom), 1'b0, 16'hFFFF);
		do_write(8'($urandom), 1'b1, 16'd512);
		do_write(8'($urandom), 1'b1, 16'd513);
		while (ring_fill() < DEPTH - 1)
			do_write(8'($urandom), 1'b0, 16'd513);
		do_write(8'($urandom), 1'b0, 16'd513);
		do_write(8'($urandom), 1'b0, 16'd513);
		do_write(8'($urandom), 1'b0, 16'd100);
		do_write(8'($urandom), 1'b1, 16'd1);
		do_write(8'($urandom), 1'b1, 16'd5000);
		do_poll(END_READ, 4'hF);
		do_poll(END_WRITE, 4'hF);
		send_word(OP_WRITE, END_READ, 8'($urandom), 1'b1, 16'd1, 4'hF);
		while (ring_fill() != 0) begin
			if (ring_fill() >= HALF_DEPTH - 2 && ring_fill() <= HALF_DEPTH + 2)
				do_poll(END_WRITE, 4'hF);
			do_read();
		end
		do_read();
	endtask

	function automatic logic [LEN_W-1:0] pick_length();
		int v;
		case ($urandom_range(0, 4))
			0: v = $urandom_range(0, 16);
			1: v = int'(limit_m) - 1 + $urandom_range(0, 2);
			2: v = $urandom_range(0, 65535);
			3: v = $urandom_range(DEPTH, 65535);
			default: v = 65535;
		endcase
		if ($urandom_range(0, 99) < 15 &&
				DEPTH - 1 - int'(ring_fill()) + 3 <= int'(limit_m))
			v = DEPTH - 1 - int'(ring_fill()) + $urandom_range(1, 3);
		return LEN_W'(v);
	endfunction

	task automatic test_random_traffic(input int idle_pct,
			input logic [LIMIT_W-1:0] limit, input int n_words);
		int               stop_at;
		int               kind;
		int               n_bytes;
		logic [LEN_W-1:0] len;
		set_atomic_limit(limit);
		sender_idle_pct = idle_pct;
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				len = pick_length();
				n_bytes = $urandom_range(1, 8);
				if (len <= 16 && $urandom_range(0, 9) == 0)
					n_bytes = (len == 0) ? 1 : int'(len);
				for (int i = 0; i < n_bytes; i++)
					do_write(8'($urandom), (i == 0) ? 1'b1 : ($urandom_range(0, 19) == 0),
						len);
			end else if (kind < 75) begin
				repeat ($urandom_range(1, 6)) do_read();
			end else if (kind < 85) begin
				do_poll(1'($urandom), 4'($urandom));
			end else begin
				send_word(op_t'($urandom_range(0, 2)), 1'($urandom), 8'($urandom),
					1'($urandom), 16'($urandom), 4'($urandom));
			end
		end
	endtask

	task automatic test_close_ends();
		do_write(8'h3C, 1'b1, 16'd4);
		do_write(8'hC3, 1'b0, 16'd4);
		do_close(END_WRITE);
		do_write(8'($urandom), 1'b1, 16'd4);
		do_write(8'($urandom), 1'b0, 16'd4);
		send_word(OP_WRITE, END_READ, 8'($urandom), 1'b1, 16'd4, 4'hF);
		do_poll(END_READ, 4'hF);
		while (ring_fill() != 0)
			do_read();
		do_read();
		do_close(END_READ);
		do_close(END_WRITE);
		do_read();
		do_poll(END_WRITE, 4'hF);
		do_write(8'($urandom), 1'b1, 16'd1);
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** byte_pipe_ring_buffer_unit: FAILED **");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_READ;
		end_select = END_READ;
		write_data = 8'h00;
		request_first = 1'b0;
		request_length = '0;
		poll_mask = 4'h0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		sender_idle_pct = 20;
		test_access_rules();
		test_fill_to_full();
		test_random_traffic(20, LIMIT_W'(DEPTH - 1), 370);
		test_random_traffic(83, LIMIT_W'(1), 370);
		test_random_traffic(0, LIMIT_W'($urandom_range(2, DEPTH - 2)), 360);
		test_close_ends();

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("** byte_pipe_ring_buffer_unit: PASSED **");
		else
			$display("** byte_pipe_ring_buffer_unit: FAILED **");
		$finish;
	end

endmodule

/* byte_pipe_ring_buffer_unit.f */
rtl/bprb_pkg.sv
rtl/bprb_ctrl.sv
rtl/bprb_dp.sv
rtl/byte_pipe_ring_buffer_unit.sv
tb/tb.sv
